### rtl/core/rle_pkg.sv
// rle_pkg: shared types and constants for the run-length image stream decoder
// phase encoding, result kinds, header field lengths
// no dependencies
`default_nettype none

package rle_pkg;

  typedef enum logic [3:0] {
    PH_SKIP_HDR  = 4'd0,
    PH_SIZE      = 4'd1,
    PH_SKIP4     = 4'd2,
    PH_GRAY      = 4'd3,
    PH_SKIP3     = 4'd4,
    PH_SKIP_ZERO = 4'd5,
    PH_COUNT     = 4'd6,
    PH_LENGTHS   = 4'd7,
    PH_COLORS    = 4'd8,
    PH_IDLE      = 4'd9
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_DIMS = 2'd0;
  localparam kind_t KIND_RUN  = 2'd1;
  localparam kind_t KIND_ERR  = 2'd2;

  localparam int MAX_RUNS_DEF = 1024;

  localparam logic [3:0] HDR_SKIP_LEN = 4'd10;
  localparam logic [3:0] WIDTH_LEN    = 4'd2;
  localparam logic [3:0] SIZE_LEN     = 4'd4;
  localparam logic [3:0] SKIP4_LEN    = 4'd4;
  localparam logic [3:0] SKIP3_LEN    = 4'd3;
  localparam logic [3:0] WORD_LEN     = 4'd4;
  localparam logic [3:0] COLOR_RED    = 4'd0;
  localparam logic [3:0] COLOR_GREEN  = 4'd1;

  localparam int GRAY_BIT = 1;

endpackage

`default_nettype wire

### rtl/core/rle_image_stream_decoder.sv
// rle_image_stream_decoder: top level of the run-length image stream decoder
// depends on rle_pkg and rle_ram
// Takes one byte of the coded stream per cycle and never holds the input for
// more than the output register: a byte is taken in every cycle in which the
// result register is empty or its transaction completes. The header yields one
// dimensions result; then the run count and that many 32-bit run lengths
// follow, and the lengths (at most MAX_RUNS) are written to a MAX_RUNS-deep
// ram. Each run color (one gray byte or three RGB bytes) yields one run result
// with its length. The ram is read
// ahead at the next run index, with a bypass for a length written in the same
// cycle, so color bytes also flow at one per cycle. A run count above MAX_RUNS
// gives one error result; after an error, a zero count or the last run, input
// is taken and dropped until reset.
`default_nettype none

module rle_image_stream_decoder #(
  parameter int MAX_RUNS = rle_pkg::MAX_RUNS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire logic [7:0]          data_byte,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output rle_pkg::kind_t           result_kind,
  output logic      [15:0]         image_width,
  output logic      [15:0]         image_height,
  output logic                     is_gray,
  output logic      [7:0]          red,
  output logic      [7:0]          green,
  output logic      [7:0]          blue,
  output logic      [31:0]         repeat_count,
  output logic                     last_run
);
  import rle_pkg::*;

  localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam logic [31:0] MAX_RUNS_W = 32'(MAX_RUNS);

  phase_t          phase, phase_next;
  logic [3:0]      byte_position, byte_position_next;
  logic [31:0]     assembly_word, assembly_word_next;
  logic [15:0]     width_reg, width_reg_next;
  logic            gray_mode, gray_mode_next;
  logic [CW-1:0]   total_runs, total_runs_next;
  logic [CW-1:0]   run_index, run_index_next;
  logic [15:0]     pending_color, pending_color_next;

  logic            accept;
  logic [3:0]      pos_inc;
  logic [31:0]     word_shift;
  logic [CW-1:0]   index_inc;
  logic            ram_we;
  logic [31:0]     ram_rdata;
  logic            bypass_hit;
  logic [31:0]     bypass_data;
  logic [31:0]     run_len;

  logic            emit;
  kind_t           res_kind;
  logic [15:0]     res_width;
  logic [15:0]     res_height;
  logic            res_gray;
  logic [7:0]      res_red;
  logic [7:0]      res_green;
  logic [7:0]      res_blue;
  logic [31:0]     res_count;
  logic            res_last;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign pos_inc    = byte_position + 4'd1;
  assign word_shift = {assembly_word[23:0], data_byte};
  assign index_inc  = run_index + CW'(1);
  assign run_len    = bypass_hit ? bypass_data : ram_rdata;

  // next state
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    assembly_word_next = assembly_word;
    width_reg_next     = width_reg;
    gray_mode_next     = gray_mode;
    total_runs_next    = total_runs;
    run_index_next     = run_index;
    pending_color_next = pending_color;
    ram_we             = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_SKIP_HDR: begin
          byte_position_next = pos_inc;
          if (pos_inc >= HDR_SKIP_LEN) begin
            byte_position_next = '0;
            phase_next         = PH_SIZE;
          end
        end
        PH_SIZE: begin
          assembly_word_next = word_shift;
          byte_position_next = pos_inc;
          if (pos_inc == WIDTH_LEN) begin
            width_reg_next     = word_shift[15:0];
            assembly_word_next = '0;
          end else if (pos_inc >= SIZE_LEN) begin
            assembly_word_next = '0;
            byte_position_next = '0;
            phase_next         = PH_SKIP4;
          end
        end
        PH_SKIP4: begin
          byte_position_next = pos_inc;
          if (pos_inc >= SKIP4_LEN) begin
            byte_position_next = '0;
            phase_next         = PH_GRAY;
          end
        end
        PH_GRAY: begin
          gray_mode_next = data_byte[GRAY_BIT];
          phase_next     = PH_SKIP3;
        end
        PH_SKIP3: begin
          byte_position_next = pos_inc;
          if (pos_inc >= SKIP3_LEN) begin
            byte_position_next = '0;
            phase_next         = PH_SKIP_ZERO;
          end
        end
        PH_SKIP_ZERO: begin
          if (data_byte == 8'd0) begin
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          assembly_word_next = word_shift;
          byte_position_next = pos_inc;
          if (pos_inc >= WORD_LEN) begin
            assembly_word_next = '0;
            byte_position_next = '0;
            run_index_next     = '0;
            if (word_shift > MAX_RUNS_W) begin
              phase_next = PH_IDLE;
            end else begin
              total_runs_next = word_shift[CW-1:0];
              phase_next      = (word_shift == 32'd0) ? PH_IDLE : PH_LENGTHS;
            end
          end
        end
        PH_LENGTHS: begin
          assembly_word_next = word_shift;
          byte_position_next = pos_inc;
          if (pos_inc >= WORD_LEN) begin
            ram_we             = 1'b1;
            assembly_word_next = '0;
            byte_position_next = '0;
            run_index_next     = index_inc;
            if (index_inc >= total_runs) begin
              run_index_next = '0;
              phase_next     = PH_COLORS;
            end
          end
        end
        PH_COLORS: begin
          priority if (gray_mode) begin
            run_index_next = index_inc;
          end else if (byte_position == COLOR_RED) begin
            pending_color_next = {data_byte, 8'd0};
            byte_position_next = 4'd1;
          end else if (byte_position == COLOR_GREEN) begin
            pending_color_next = {pending_color[15:8], data_byte};
            byte_position_next = 4'd2;
          end else begin
            byte_position_next = '0;
            run_index_next     = index_inc;
          end
          if (run_index_next != run_index && index_inc >= total_runs) begin
            phase_next = PH_IDLE;
          end
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // result of this transaction
  always_comb begin
    emit       = 1'b0;
    res_kind   = KIND_DIMS;
    res_width  = '0;
    res_height = '0;
    res_gray   = 1'b0;
    res_red    = '0;
    res_green  = '0;
    res_blue   = '0;
    res_count  = '0;
    res_last   = 1'b0;
    unique case (phase)
      PH_SIZE: begin
        if (pos_inc != WIDTH_LEN && pos_inc >= SIZE_LEN) begin
          emit       = 1'b1;
          res_kind   = KIND_DIMS;
          res_width  = width_reg;
          res_height = word_shift[15:0];
        end
      end
      PH_COUNT: begin
        if (pos_inc >= WORD_LEN && word_shift > MAX_RUNS_W) begin
          emit     = 1'b1;
          res_kind = KIND_ERR;
        end
      end
      PH_COLORS: begin
        if (gray_mode || (byte_position != COLOR_RED && byte_position != COLOR_GREEN)) begin
          emit      = 1'b1;
          res_kind  = KIND_RUN;
          res_gray  = gray_mode;
          res_red   = gray_mode ? data_byte : pending_color[15:8];
          res_green = gray_mode ? data_byte : pending_color[7:0];
          res_blue  = data_byte;
          res_count = run_len;
          res_last  = index_inc >= total_runs;
        end
      end
      default: begin
      end
    endcase
  end

  // run length store, read ahead at the next run index
  rle_ram #(
    .WIDTH (32),
    .DEPTH (MAX_RUNS)
  ) u_len_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (run_index[IW-1:0]),
    .wdata (word_shift),
    .raddr (run_index_next[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    bypass_hit  <= ram_we && (run_index[IW-1:0] == run_index_next[IW-1:0]);
    bypass_data <= word_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SKIP_HDR;
      byte_position <= '0;
      assembly_word <= '0;
      width_reg     <= '0;
      gray_mode     <= 1'b0;
      total_runs    <= '0;
      run_index     <= '0;
      pending_color <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      assembly_word <= assembly_word_next;
      width_reg     <= width_reg_next;
      gray_mode     <= gray_mode_next;
      total_runs    <= total_runs_next;
      run_index     <= run_index_next;
      pending_color <= pending_color_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result_kind  <= res_kind;
      image_width  <= res_width;
      image_height <= res_height;
      is_gray      <= res_gray;
      red          <= res_red;
      green        <= res_green;
      blue         <= res_blue;
      repeat_count <= res_count;
      last_run     <= res_last;
    end
  end

`ifndef SYNTH
  a_run_index_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COLORS) |-> (run_index < total_runs))
    else $error("run index beyond run count in color phase");

  a_total_runs_bound: assert property (@(posedge clk) disable iff (rst)
    total_runs <= CW'(MAX_RUNS))
    else $error("stored run count above store depth");

  a_last_ends_image: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ((result_kind == KIND_RUN && last_run) || result_kind == KIND_ERR))
    |-> (phase == PH_IDLE))
    else $error("decoder still active after final or error result");
`endif

endmodule

`default_nettype wire

### rtl/core/rle_ram.sv
// rle_ram: generic single-clock ram, one write port, one read port
// read data registered, read-before-write on the same address
// no dependencies
`default_nettype none

module rle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sim/tb_rle_image_stream_decoder.sv
// tb_rle_image_stream_decoder: self-checking testbench for the run-length image stream decoder
// streams one coded image byte by byte, predicts every result and compares it field by field
// depends on rle_pkg and the rle_image_stream_decoder rtl
`timescale 1ns / 100ps

module tb_rle_image_stream_decoder;
  import rle_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] width;
    logic [15:0] height;
    logic        gray;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [31:0] length;
    logic        last;
  } image_result_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [7:0]  data_byte;
  logic        result_valid;
  logic        result_stall = 1'b0;
  kind_t       result_kind;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        is_gray;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] repeat_count;
  logic        last_run;

  rle_image_stream_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .image_width  (image_width),
    .image_height (image_height),
    .is_gray      (is_gray),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .repeat_count (repeat_count),
    .last_run     (last_run)
  );

  // decoder state as predicted
  phase_t      dec_phase;
  logic [7:0]  dec_pos;
  logic [31:0] dec_word;
  logic [15:0] dec_width;
  logic        dec_gray;
  logic [10:0] dec_total;
  logic [10:0] dec_index;
  logic [15:0] dec_color;
  logic [31:0] run_lengths [0:MAX_RUNS_DEF-1];

  image_result_t expected_results [$];

  logic tx_idling;
  logic rx_idling;
  int   stall_left = 0;
  logic use_gray;
  int   error_count = 0;
  int   bytes_accepted = 0;
  int   results_checked = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic emit_run(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    image_result_t res;
    res = '0;
    res.kind = KIND_RUN;
    res.gray = dec_gray;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.length = (dec_index < MAX_RUNS_DEF) ? run_lengths[dec_index[9:0]] : 32'd0;
    dec_index = dec_index + 11'd1;
    if (dec_index >= dec_total) begin
      res.last = 1'b1;
      dec_phase = PH_IDLE;
    end
    expected_results.push_back(res);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    image_result_t res;
    logic [31:0]   count;
    res = '0;
    case (dec_phase)
      PH_SKIP_HDR: begin
        dec_pos = dec_pos + 8'd1;
        if (dec_pos >= HDR_SKIP_LEN) begin
          dec_pos = '0;
          dec_phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        dec_word = {dec_word[23:0], b};
        dec_pos = dec_pos + 8'd1;
        if (dec_pos == WIDTH_LEN) begin
          dec_width = dec_word[15:0];
          dec_word = '0;
        end else if (dec_pos >= SIZE_LEN) begin
          res.kind = KIND_DIMS;
          res.width = dec_width;
          res.height = dec_word[15:0];
          expected_results.push_back(res);
          dec_word = '0;
          dec_pos = '0;
          dec_phase = PH_SKIP4;
        end
      end
      PH_SKIP4: begin
        dec_pos = dec_pos + 8'd1;
        if (dec_pos >= SKIP4_LEN) begin
          dec_pos = '0;
          dec_phase = PH_GRAY;
        end
      end
      PH_GRAY: begin
        dec_gray = b[GRAY_BIT];
        dec_phase = PH_SKIP3;
      end
      PH_SKIP3: begin
        dec_pos = dec_pos + 8'd1;
        if (dec_pos >= SKIP3_LEN) begin
          dec_pos = '0;
          dec_phase = PH_SKIP_ZERO;
        end
      end
      PH_SKIP_ZERO: begin
        if (b == 8'h00) dec_phase = PH_COUNT;
      end
      PH_COUNT: begin
        dec_word = {dec_word[23:0], b};
        dec_pos = dec_pos + 8'd1;
        if (dec_pos >= WORD_LEN) begin
          count = dec_word;
          dec_word = '0;
          dec_pos = '0;
          dec_index = '0;
          if (count > MAX_RUNS_DEF) begin
            dec_phase = PH_IDLE;
            res.kind = KIND_ERR;
            expected_results.push_back(res);
          end else begin
            dec_total = count[10:0];
            dec_phase = (count == 0) ? PH_IDLE : PH_LENGTHS;
          end
        end
      end
      PH_LENGTHS: begin
        dec_word = {dec_word[23:0], b};
        dec_pos = dec_pos + 8'd1;
        if (dec_pos >= WORD_LEN) begin
          if (dec_index < MAX_RUNS_DEF) run_lengths[dec_index[9:0]] = dec_word;
          dec_word = '0;
          dec_pos = '0;
          dec_index = dec_index + 11'd1;
          if (dec_index >= dec_total) begin
            dec_index = '0;
            dec_phase = PH_COLORS;
          end
        end
      end
      PH_COLORS: begin
        if (dec_gray) begin
          emit_run(b, b, b);
        end else if (dec_pos == COLOR_RED) begin
          dec_color = {b, 8'h00};
          dec_pos = dec_pos + 8'd1;
        end else if (dec_pos == COLOR_GREEN) begin
          dec_color[7:0] = b;
          dec_pos = dec_pos + 8'd1;
        end else begin
          dec_pos = '0;
          emit_run(dec_color[15:8], dec_color[7:0], b);
        end
      end
      default: ;
    endcase
  endtask

  // entered and left just after a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    item_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (item_stall);
    decode_byte(b);
    bytes_accepted++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    image_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual kind %0d",
                 $time, result_kind);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_kind));
        check_field("image_width", 32'(want.width), 32'(image_width));
        check_field("image_height", 32'(want.height), 32'(image_height));
        check_field("is_gray", 32'(want.gray), 32'(is_gray));
        check_field("red", 32'(want.red), 32'(red));
        check_field("green", 32'(want.green), 32'(green));
        check_field("blue", 32'(want.blue), 32'(blue));
        check_field("repeat_count", want.length, repeat_count);
        check_field("last_run", 32'(want.last), 32'(last_run));
        results_checked++;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (rx_idling && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 10);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // header with extreme skip bytes, sizes, gray flag and noise before the zero marker
  task automatic test_header();
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  flag_byte;
    w = 16'($urandom);
    h = 16'($urandom);
    send_byte(8'h00);
    send_byte(8'hFF);
    repeat (8) send_byte(8'($urandom));
    send_byte(w[15:8]);
    send_byte(w[7:0]);
    send_byte(h[15:8]);
    send_byte(h[7:0]);
    repeat (4) send_byte(8'($urandom));
    flag_byte = 8'($urandom);
    flag_byte[GRAY_BIT] = use_gray;
    send_byte(flag_byte);
    repeat (3) send_byte(8'($urandom));
    send_byte(8'hFF);
    repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);
  endtask

  task automatic test_run_table(input int n);
    logic [31:0] len;
    send_word(n);
    for (int i = 0; i < n; i++) begin
      case (i)
        0:       len = 32'd0;
        1:       len = 32'hFFFF_FFFF;
        2:       len = 32'd1;
        default: len = $urandom;
      endcase
      send_word(len);
    end
  endtask

  task automatic test_run_colors(input int n);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      tx_idling = (i < n * 4 / 5) && ((i % 64) < 48);
      rx_idling = (i < n * 4 / 5) && ((i % 64) >= 8);
      if (i == n / 2) wait_for_drain();
      if (i < 2) begin
        r = i ? 8'hFF : 8'h00;
        g = r;
        b = r;
      end else begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end
      send_byte(r);
      if (!use_gray) begin
        send_byte(g);
        send_byte(b);
      end
    end
  endtask

  // bytes after the last run must be dropped without a result
  task automatic test_after_image();
    repeat (24) send_byte(8'($urandom));
  endtask

  initial begin
    int n_runs;
    rst = 1'b1;
    item_valid = 1'b0;
    data_byte = 8'h00;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    dec_phase = PH_SKIP_HDR;
    dec_pos = '0;
    dec_word = '0;
    dec_width = '0;
    dec_gray = 1'b0;
    dec_total = '0;
    dec_index = '0;
    dec_color = '0;
    use_gray = 1'($urandom_range(0, 1));
    n_runs = use_gray ? 300 : 215;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_header();
    test_run_table(n_runs);
    test_run_colors(n_runs);
    test_after_image();

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("run covered %0d stream bytes and %0d checked results: header, %0d %s runs,",
             bytes_accepted, results_checked, n_runs, use_gray ? "gray" : "rgb");
    $display("run lengths at zero and all ones, and bytes dropped after the last run");
    if (error_count == 0) begin
      $display("tb_rle_image_stream_decoder: done, clean");
    end else begin
      $display("tb_rle_image_stream_decoder: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_rle_image_stream_decoder: done, errors");
    $finish;
  end

endmodule
